FILE: rtl/core/ptd_pkg.sv
// Package for the point-to-triangle distance core: types, widths and constants.
// Used by ptd_div and point_triangle_distance_core; depends on nothing.
package ptd_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS_DEF = 8;
  localparam int DIST_W = 25;
  localparam int QUO_BITS = 2 * DIST_W;

  localparam int PLANE_NUM_W_DEF = 6 * COORD_BITS + 10 + 2 * FRAC_BITS_DEF;
  localparam int PLANE_DEN_W_DEF = 4 * COORD_BITS + 4;

  // Segment endpoints: edges b-c, c-a, a-b.
  localparam logic [1:0] EDGE_FROM [3] = '{2'd1, 2'd2, 2'd0};
  localparam logic [1:0] EDGE_TO [3] = '{2'd2, 2'd0, 2'd1};

  // Axis rotation for cross products.
  localparam logic [1:0] NEXT_AXIS [3] = '{2'd1, 2'd2, 2'd0};
  localparam logic [1:0] PREV_AXIS [3] = '{2'd2, 2'd0, 2'd1};

  typedef enum logic [1:0] {
    SEG_START,
    SEG_END,
    SEG_MID
  } ptd_seg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] query_z;
  } ptd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              inside_res;
    logic              degenerate;
  } ptd_out_t;

  typedef struct packed {
    logic valid;
    logic in_tri;
    logic degen;
  } ptd_tag_t;

endpackage

FILE: rtl/core/ptd_div.sv
// Pipelined restoring divider with a saturating quotient, one quotient bit per stage.
// Depends on ptd_pkg for default widths.
module ptd_div import ptd_pkg::*; #(
  parameter int NUM_W = PLANE_NUM_W_DEF,
  parameter int DEN_W = PLANE_DEN_W_DEF,
  parameter int QUO_W = QUO_BITS
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int HW = NUM_W - QUO_W;
  localparam int XW = (HW > DEN_W) ? HW : DEN_W;

  logic [DEN_W-1:0] rem [QUO_W];
  logic [QUO_W-1:0] lo  [QUO_W];
  logic [DEN_W-1:0] dn  [QUO_W];
  logic [QUO_W-1:0] q   [QUO_W+1];
  logic             sat [QUO_W+1];

  // A quotient of 2^QUO_W or more saturates.
  always_ff @(posedge clk) begin
    sat[0] <= XW'(num[NUM_W-1:QUO_W]) >= XW'(den);
    rem[0] <= DEN_W'(num[NUM_W-1:QUO_W]);
    lo[0]  <= num[QUO_W-1:0];
    dn[0]  <= den;
    q[0]   <= '0;
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [DEN_W:0] t;
    logic           ge;

    always_comb begin
      t  = {rem[j], lo[j][QUO_W-1-j]};
      ge = t >= {1'b0, dn[j]};
    end

    always_ff @(posedge clk) begin
      q[j+1]   <= {q[j][QUO_W-2:0], ge};
      sat[j+1] <= sat[j];
    end

    if (j < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem[j+1] <= ge ? DEN_W'(t - {1'b0, dn[j]}) : DEN_W'(t);
        lo[j+1]  <= lo[j];
        dn[j+1]  <= dn[j];
      end
    end
  end

  assign quo = sat[QUO_W] ? '1 : q[QUO_W];

endmodule

FILE: rtl/core/point_triangle_distance_core.sv
// Point-to-triangle distance core: top level with the full arithmetic pipeline.
// Depends on ptd_pkg and ptd_div.
//
// The core takes one transaction every clock cycle and never raises busy. Each result
// appears on result with done high for one cycle. Eight stages form the normal,
// barycentric tests and edge terms, three dividers of 51 stages each form the squared
// distance in fixed point, one stage picks the smallest, and a 25-stage square root
// unit finishes it. Results come out in the order the transactions went in. The
// receiver cannot hold results off, so it must take each one in the cycle in which
// done is high.
module point_triangle_distance_core import ptd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  ptd_in_t  operands,
  output logic     done,
  output ptd_out_t result
);

  localparam int CW    = COORD_BITS;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * CW + 2;
  localparam int NW    = 2 * CW + 3;
  localparam int SQW   = 2 * CW + 2;
  localparam int SSW   = 2 * CW + 4;
  localparam int N2W   = 2 * NW;
  localparam int S5W   = N2W + 2;
  localparam int NNW   = 4 * CW + 4;
  localparam int ENW   = 2 * SQW;
  localparam int MW    = 3 * CW + 5;
  localparam int HLW   = (MW + 1) / 2;
  localparam int HHW   = MW - HLW;
  localparam int DSW   = 2 * MW;
  localparam int PNW   = 2 * MW + 2 * FRAC_BITS;
  localparam int ENSW  = ENW + 2 * FRAC_BITS;
  localparam int ENUMW = (ENSW > QUO_BITS) ? ENSW : QUO_BITS + 1;
  localparam int RW    = DIST_W;
  localparam int DIV_LAT  = QUO_BITS + 1;
  localparam int PIPE_LAT = 9 + DIV_LAT + RW;

  logic signed [CW-1:0] pts [4][3];
  logic [7:0] vld;

  assign busy = 1'b0;

  always_comb begin
    pts[0][0] = operands.a_x;
    pts[0][1] = operands.a_y;
    pts[0][2] = operands.a_z;
    pts[1][0] = operands.b_x;
    pts[1][1] = operands.b_y;
    pts[1][2] = operands.b_z;
    pts[2][0] = operands.c_x;
    pts[2][1] = operands.c_y;
    pts[2][2] = operands.c_z;
    pts[3][0] = operands.query_x;
    pts[3][1] = operands.query_y;
    pts[3][2] = operands.query_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:0], start && !busy};
    end
  end

  // Stage 1: difference vectors.
  logic signed [DW-1:0] s1_u [3], s1_v [3], s1_w [3];
  logic signed [DW-1:0] s1_ed [3][3], s1_eq [3][3], s1_er [3][3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_u[i] <= DW'(pts[1][i]) - DW'(pts[0][i]);
      s1_v[i] <= DW'(pts[2][i]) - DW'(pts[0][i]);
      s1_w[i] <= DW'(pts[3][i]) - DW'(pts[0][i]);
      for (int k = 0; k < 3; k++) begin
        s1_ed[k][i] <= DW'(pts[EDGE_TO[k]][i]) - DW'(pts[EDGE_FROM[k]][i]);
        s1_eq[k][i] <= DW'(pts[3][i]) - DW'(pts[EDGE_FROM[k]][i]);
        s1_er[k][i] <= DW'(pts[3][i]) - DW'(pts[EDGE_TO[k]][i]);
      end
    end
  end

  // Stage 2: cross product terms and edge component products.
  logic signed [PW-1:0] s2_uv_p [3], s2_uv_m [3], s2_uw_p [3], s2_uw_m [3];
  logic signed [PW-1:0] s2_wv_p [3], s2_wv_m [3];
  logic signed [PW-1:0] s2_dd [3][3], s2_dq [3][3], s2_qq [3][3], s2_rr [3][3];
  logic signed [DW-1:0] s2_w [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_uv_p[i] <= PW'(s1_u[NEXT_AXIS[i]]) * PW'(s1_v[PREV_AXIS[i]]);
      s2_uv_m[i] <= PW'(s1_u[PREV_AXIS[i]]) * PW'(s1_v[NEXT_AXIS[i]]);
      s2_uw_p[i] <= PW'(s1_u[NEXT_AXIS[i]]) * PW'(s1_w[PREV_AXIS[i]]);
      s2_uw_m[i] <= PW'(s1_u[PREV_AXIS[i]]) * PW'(s1_w[NEXT_AXIS[i]]);
      s2_wv_p[i] <= PW'(s1_w[NEXT_AXIS[i]]) * PW'(s1_v[PREV_AXIS[i]]);
      s2_wv_m[i] <= PW'(s1_w[PREV_AXIS[i]]) * PW'(s1_v[NEXT_AXIS[i]]);
      s2_w[i]    <= s1_w[i];
      for (int k = 0; k < 3; k++) begin
        s2_dd[k][i] <= PW'(s1_ed[k][i]) * PW'(s1_ed[k][i]);
        s2_dq[k][i] <= PW'(s1_ed[k][i]) * PW'(s1_eq[k][i]);
        s2_qq[k][i] <= PW'(s1_eq[k][i]) * PW'(s1_eq[k][i]);
        s2_rr[k][i] <= PW'(s1_er[k][i]) * PW'(s1_er[k][i]);
      end
    end
  end

  // Stage 3: cross products and edge dot products.
  logic signed [NW-1:0] s3_n [3], s3_uw [3], s3_wv [3];
  logic signed [DW-1:0] s3_w [3];
  logic [SQW-1:0]       s3_dd [3], s3_qq [3], s3_rr [3];
  logic signed [NW-1:0] s3_dq [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_n[i]  <= NW'(s2_uv_p[i]) - NW'(s2_uv_m[i]);
      s3_uw[i] <= NW'(s2_uw_p[i]) - NW'(s2_uw_m[i]);
      s3_wv[i] <= NW'(s2_wv_p[i]) - NW'(s2_wv_m[i]);
      s3_w[i]  <= s2_w[i];
    end
    for (int k = 0; k < 3; k++) begin
      s3_dd[k] <= SQW'(SSW'(s2_dd[k][0]) + SSW'(s2_dd[k][1]) + SSW'(s2_dd[k][2]));
      s3_qq[k] <= SQW'(SSW'(s2_qq[k][0]) + SSW'(s2_qq[k][1]) + SSW'(s2_qq[k][2]));
      s3_rr[k] <= SQW'(SSW'(s2_rr[k][0]) + SSW'(s2_rr[k][1]) + SSW'(s2_rr[k][2]));
      s3_dq[k] <= NW'(SSW'(s2_dq[k][0]) + SSW'(s2_dq[k][1]) + SSW'(s2_dq[k][2]));
    end
  end

  // Stage 4: plane products, edge products and the clamp decision.
  logic signed [N2W-1:0] s4_nn_p [3], s4_g_p [3], s4_b_p [3], s4_d_p [3];
  logic [ENW-1:0]        s4_qd [3], s4_dq2 [3];
  logic [SQW-1:0]        s4_dd [3], s4_qq [3], s4_rr [3];
  ptd_seg_t              s4_seg [3];
  ptd_seg_t              seg [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s3_dd[k] == '0 || s3_dq[k] <= 0) begin
        seg[k] = SEG_START;
      end else if (s3_dq[k] >= $signed({1'b0, s3_dd[k]})) begin
        seg[k] = SEG_END;
      end else begin
        seg[k] = SEG_MID;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s4_nn_p[i] <= N2W'(s3_n[i]) * N2W'(s3_n[i]);
      s4_g_p[i]  <= N2W'(s3_uw[i]) * N2W'(s3_n[i]);
      s4_b_p[i]  <= N2W'(s3_wv[i]) * N2W'(s3_n[i]);
      s4_d_p[i]  <= N2W'(s3_n[i]) * N2W'(s3_w[i]);
    end
    for (int k = 0; k < 3; k++) begin
      s4_qd[k]  <= ENW'(s3_qq[k]) * ENW'(s3_dd[k]);
      s4_dq2[k] <= ENW'(s3_dq[k][SQW-1:0]) * ENW'(s3_dq[k][SQW-1:0]);
      s4_dd[k]  <= s3_dd[k];
      s4_qq[k]  <= s3_qq[k];
      s4_rr[k]  <= s3_rr[k];
      s4_seg[k] <= seg[k];
    end
  end

  // Stage 5: plane dot products and edge numerator and denominator.
  logic [NNW-1:0]        s5_nn;
  logic signed [S5W-1:0] s5_g, s5_b, s5_d;
  logic [ENW-1:0]        s5_enum [3];
  logic [SQW-1:0]        s5_eden [3];

  always_ff @(posedge clk) begin
    s5_nn <= NNW'(S5W'(s4_nn_p[0]) + S5W'(s4_nn_p[1]) + S5W'(s4_nn_p[2]));
    s5_g  <= S5W'(s4_g_p[0]) + S5W'(s4_g_p[1]) + S5W'(s4_g_p[2]);
    s5_b  <= S5W'(s4_b_p[0]) + S5W'(s4_b_p[1]) + S5W'(s4_b_p[2]);
    s5_d  <= S5W'(s4_d_p[0]) + S5W'(s4_d_p[1]) + S5W'(s4_d_p[2]);
    for (int k = 0; k < 3; k++) begin
      case (s4_seg[k])
        SEG_END: begin
          s5_enum[k] <= ENW'(s4_rr[k]);
          s5_eden[k] <= SQW'(1);
        end
        SEG_MID: begin
          s5_enum[k] <= s4_qd[k] - s4_dq2[k];
          s5_eden[k] <= s4_dd[k];
        end
        default: begin
          s5_enum[k] <= ENW'(s4_qq[k]);
          s5_eden[k] <= SQW'(1);
        end
      endcase
    end
  end

  // Stage 6: inside test and plane distance magnitude.
  logic           s6_inside, s6_degen;
  logic [NNW-1:0] s6_nn;
  logic [MW-1:0]  s6_dmag;
  logic [ENW-1:0] s6_enum [3];
  logic [SQW-1:0] s6_eden [3];

  always_ff @(posedge clk) begin
    s6_degen  <= s5_nn == '0;
    s6_inside <= (s5_nn != '0) && !s5_g[S5W-1] && !s5_b[S5W-1] &&
                 ((S5W+1)'(s5_g) + (S5W+1)'(s5_b) <= $signed((S5W+1)'(s5_nn)));
    s6_nn     <= s5_nn;
    s6_dmag   <= MW'(s5_d[S5W-1] ? -s5_d : s5_d);
    s6_enum   <= s5_enum;
    s6_eden   <= s5_eden;
  end

  // Stage 7: partial products of the squared plane distance.
  logic                   s7_inside, s7_degen;
  logic [NNW-1:0]         s7_nn;
  logic [2*HHW-1:0]       s7_hh;
  logic [HHW+HLW-1:0]     s7_hl;
  logic [2*HLW-1:0]       s7_ll;
  logic [ENW-1:0]         s7_enum [3];
  logic [SQW-1:0]         s7_eden [3];

  always_ff @(posedge clk) begin
    s7_inside <= s6_inside;
    s7_degen  <= s6_degen;
    s7_nn     <= s6_nn;
    s7_hh     <= (2*HHW)'(s6_dmag[MW-1:HLW]) * (2*HHW)'(s6_dmag[MW-1:HLW]);
    s7_hl     <= (HHW+HLW)'(s6_dmag[MW-1:HLW]) * (HHW+HLW)'(s6_dmag[HLW-1:0]);
    s7_ll     <= (2*HLW)'(s6_dmag[HLW-1:0]) * (2*HLW)'(s6_dmag[HLW-1:0]);
    s7_enum   <= s6_enum;
    s7_eden   <= s6_eden;
  end

  // Stage 8: divider operands.
  logic              s8_inside, s8_degen;
  logic [PNW-1:0]    s8_num0;
  logic [NNW-1:0]    s8_den0;
  logic [ENUMW-1:0]  s8_num1, s8_num2;
  logic [SQW-1:0]    s8_den1, s8_den2;
  logic [DSW-1:0]    dsq;

  assign dsq = (DSW'(s7_hh) << (2 * HLW)) + (DSW'(s7_hl) << (HLW + 1)) + DSW'(s7_ll);

  always_ff @(posedge clk) begin
    s8_inside <= s7_inside;
    s8_degen  <= s7_degen;
    s8_num0   <= s7_inside ? (PNW'(dsq) << (2 * FRAC_BITS))
                           : (PNW'(s7_enum[0]) << (2 * FRAC_BITS));
    s8_den0   <= s7_inside ? s7_nn : NNW'(s7_eden[0]);
    s8_num1   <= ENUMW'(s7_enum[1]) << (2 * FRAC_BITS);
    s8_num2   <= ENUMW'(s7_enum[2]) << (2 * FRAC_BITS);
    s8_den1   <= s7_eden[1];
    s8_den2   <= s7_eden[2];
  end

  logic [QUO_BITS-1:0] quo0, quo1, quo2;

  ptd_div #(.NUM_W(PNW), .DEN_W(NNW), .QUO_W(QUO_BITS)) u_div0 (
    .clk(clk), .num(s8_num0), .den(s8_den0), .quo(quo0)
  );

  ptd_div #(.NUM_W(ENUMW), .DEN_W(SQW), .QUO_W(QUO_BITS)) u_div1 (
    .clk(clk), .num(s8_num1), .den(s8_den1), .quo(quo1)
  );

  ptd_div #(.NUM_W(ENUMW), .DEN_W(SQW), .QUO_W(QUO_BITS)) u_div2 (
    .clk(clk), .num(s8_num2), .den(s8_den2), .quo(quo2)
  );

  ptd_tag_t side [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DIV_LAT; j++) begin
        side[j] <= '0;
      end
    end else begin
      side[0] <= '{valid: vld[7], in_tri: s8_inside, degen: s8_degen};
      for (int j = 1; j < DIV_LAT; j++) begin
        side[j] <= side[j-1];
      end
    end
  end

  // Squared plane distance if inside, else the smallest squared edge distance, then the square root one bit per stage.
  ptd_tag_t            sq_tag  [RW+1];
  logic [QUO_BITS-1:0] sq_q    [RW];
  logic [RW:0]         sq_rem  [RW];
  logic [RW-1:0]       sq_root [RW+1];
  logic [QUO_BITS-1:0] qmin;
  logic                c01, c02, c12;

  always_comb begin
    c01 = quo0 <= quo1;
    c02 = quo0 <= quo2;
    c12 = quo1 <= quo2;
    if (c01 && c02) begin
      qmin = quo0;
    end else if (!c01 && c12) begin
      qmin = quo1;
    end else begin
      qmin = quo2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_tag[0] <= '0;
    end else begin
      sq_tag[0] <= side[DIV_LAT-1];
    end
    sq_q[0]    <= side[DIV_LAT-1].in_tri ? quo0 : qmin;
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int BI = 2 * (RW - 1 - k);
    logic [RW+2:0] t;
    logic [RW+2:0] trial;
    logic          ge;

    always_comb begin
      t     = {sq_rem[k], sq_q[k][BI+1:BI]};
      trial = (RW+3)'({sq_root[k], 2'b01});
      ge    = t >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_tag[k+1] <= '0;
      end else begin
        sq_tag[k+1] <= sq_tag[k];
      end
      sq_root[k+1] <= {sq_root[k][RW-2:0], ge};
    end

    if (k < RW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        sq_q[k+1]   <= sq_q[k];
        sq_rem[k+1] <= ge ? (RW+1)'(t - trial) : (RW+1)'(t);
      end
    end
  end

  assign done              = sq_tag[RW].valid;
  assign result.distance   = sq_root[RW];
  assign result.inside_res = sq_tag[RW].in_tri;
  assign result.degenerate = sq_tag[RW].degen;

  // Every result belongs to a transaction taken a fixed time earlier.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching transaction");

  // The plane distance is never used for a zero-area triangle.
  a_inside_degen: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.inside_res && result.degenerate))
    else $error("inside result flagged degenerate");

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");

endmodule
